// ===== rtl/cmf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cmf_pkg
// Shared types, constants and the byte-wide CRC-32 update for the framer.
// ============================================================================
package cmf_pkg;

    // Frame constants.
    localparam logic [7:0]  SYNC_FIRST       = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND      = 8'hFF;
    localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
    localparam logic [15:0] MIN_LENGTH_FIELD = 16'd4;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One command per accepted item that produces frame bytes.
    typedef struct packed {
        logic        start;        // Emit the six header bytes first.
        logic        emit;         // Emit the payload byte.
        logic        last;         // Emit the CRC trailer afterwards.
        logic [7:0]  data;         // Payload byte.
        logic [15:0] msg_type;     // Type word for the header.
        logic [15:0] length_field; // Length word for the header.
    } cmd_t;

    // Byte positions that the back part walks through for one command.
    typedef enum logic [3:0] {
        STEP_SYNC0,
        STEP_SYNC1,
        STEP_LEN_LO,
        STEP_LEN_HI,
        STEP_TYPE_LO,
        STEP_TYPE_HI,
        STEP_PAYLOAD,
        STEP_CRC0,
        STEP_CRC1,
        STEP_CRC2,
        STEP_CRC3
    } step_t;

    // Reflected CRC-32 update over one byte, one bit per step.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data_in);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data_in};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/cmf_front.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cmf_front
// Accepts input items, tracks the open message and turns each useful item
// into one command for the back part. Stray bytes are dropped here.
// ============================================================================
module cmf_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    payload_byte,
    input  logic          starts_message,
    input  logic [15:0]   message_type,
    input  logic [8:0]    payload_length,
    output logic          push,
    output cmf_pkg::cmd_t push_cmd,
    input  logic          queue_full
);
    import cmf_pkg::*;

    localparam int         BLW     = $clog2(MAX_PAYLOAD + 1);
    localparam logic [8:0] MAX_LEN = 9'(MAX_PAYLOAD);

    logic           in_message_reg, in_message_next;
    logic [BLW-1:0] bytes_left_reg, bytes_left_next;
    logic [8:0]     len_sat;
    logic [15:0]    len_plus;
    logic           accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Saturate the length and form the header length word.
    always_comb
    begin
        len_sat  = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;
        len_plus = 16'(len_sat) + 16'd2;
    end

    // Classify the item and build its command.
    always_comb
    begin
        in_message_next       = in_message_reg;
        bytes_left_next       = bytes_left_reg;
        push                  = 1'b0;
        push_cmd.start        = starts_message;
        push_cmd.data         = payload_byte;
        push_cmd.msg_type     = message_type;
        push_cmd.length_field = (len_plus < MIN_LENGTH_FIELD) ? MIN_LENGTH_FIELD
                                                              : len_plus;
        push_cmd.emit         = 1'b1;
        push_cmd.last         = 1'b0;
        if (starts_message)
        begin
            push_cmd.emit = (len_sat != 9'd0);
            push_cmd.last = (len_sat <= 9'd1);
        end
        else
        begin
            push_cmd.last = (bytes_left_reg == BLW'(1));
        end

        if (accept)
        begin
            if (starts_message)
            begin
                push            = 1'b1;
                in_message_next = (len_sat > 9'd1);
                bytes_left_next = BLW'(len_sat) - BLW'(1);
            end
            else if (in_message_reg)
            begin
                push            = 1'b1;
                in_message_next = (bytes_left_reg != BLW'(1));
                bytes_left_next = bytes_left_reg - BLW'(1);
            end
        end
    end

    // Message tracking state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_message_reg <= 1'b0;
            bytes_left_reg <= '0;
        end
        else
        begin
            in_message_reg <= in_message_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ===== rtl/cmf_queue.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cmf_queue
// Short command queue that decouples the front part from the back part.
// ============================================================================
module cmf_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmf_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          head_valid,
    output cmf_pkg::cmd_t head_cmd,
    output logic          full
);
    import cmf_pkg::*;

    cmd_t                entries_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full       = (count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QUEUE_AW + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/cmf_back.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cmf_back
// Walks each command through its frame bytes, keeps the running CRC and
// drives the registered output stream.
// ============================================================================
module cmf_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  cmf_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    frame_byte,
    output logic          frame_end
);
    import cmf_pkg::*;

    cmd_t        cmd_reg;
    logic        cmd_valid_reg, cmd_valid_next;
    step_t       step_reg, step_next;
    logic [31:0] crc_reg, crc_next;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_end_reg;

    logic        adv;
    logic        done;
    step_t       follow_step;
    logic [7:0]  cur_byte;
    logic        cur_covered;
    logic        cur_end;

    // A byte moves to the output register when it is empty or being drained.
    assign adv = cmd_valid_reg && (!out_valid_reg || out_ready);

    // Next-step logic.
    always_comb
    begin
        follow_step = step_reg;
        done        = 1'b0;
        case (step_reg)
            STEP_SYNC0:   follow_step = STEP_SYNC1;
            STEP_SYNC1:   follow_step = STEP_LEN_LO;
            STEP_LEN_LO:  follow_step = STEP_LEN_HI;
            STEP_LEN_HI:  follow_step = STEP_TYPE_LO;
            STEP_TYPE_LO: follow_step = STEP_TYPE_HI;
            STEP_TYPE_HI: follow_step = cmd_reg.emit ? STEP_PAYLOAD : STEP_CRC0;
            STEP_PAYLOAD:
            begin
                follow_step = STEP_CRC0;
                done        = !cmd_reg.last;
            end
            STEP_CRC0:    follow_step = STEP_CRC1;
            STEP_CRC1:    follow_step = STEP_CRC2;
            STEP_CRC2:    follow_step = STEP_CRC3;
            STEP_CRC3:    done        = 1'b1;
            default:      done        = 1'b1;
        endcase
    end

    // Command load and step register updates.
    always_comb
    begin
        pop            = head_valid && (!cmd_valid_reg || (adv && done));
        cmd_valid_next = cmd_valid_reg;
        step_next      = step_reg;
        if (!cmd_valid_reg || (adv && done))
        begin
            cmd_valid_next = head_valid;
            step_next      = head_cmd.start ? STEP_SYNC0 : STEP_PAYLOAD;
        end
        else if (adv)
        begin
            step_next = follow_step;
        end
    end

    // Output byte for the current step.
    always_comb
    begin
        cur_covered = 1'b1;
        cur_end     = 1'b0;
        case (step_reg)
            STEP_SYNC0:   cur_byte = SYNC_FIRST;
            STEP_SYNC1:   cur_byte = SYNC_SECOND;
            STEP_LEN_LO:  cur_byte = cmd_reg.length_field[7:0];
            STEP_LEN_HI:  cur_byte = cmd_reg.length_field[15:8];
            STEP_TYPE_LO: cur_byte = cmd_reg.msg_type[7:0];
            STEP_TYPE_HI: cur_byte = cmd_reg.msg_type[15:8];
            STEP_PAYLOAD: cur_byte = cmd_reg.data;
            STEP_CRC0:
            begin
                cur_byte    = crc_reg[7:0];
                cur_covered = 1'b0;
            end
            STEP_CRC1:
            begin
                cur_byte    = crc_reg[15:8];
                cur_covered = 1'b0;
            end
            STEP_CRC2:
            begin
                cur_byte    = crc_reg[23:16];
                cur_covered = 1'b0;
            end
            STEP_CRC3:
            begin
                cur_byte    = crc_reg[31:24];
                cur_covered = 1'b0;
                cur_end     = 1'b1;
            end
            default:
            begin
                cur_byte    = 8'd0;
                cur_covered = 1'b0;
            end
        endcase
    end

    // Running CRC; the first sync byte restarts it, which also drops an
    // abandoned frame's partial CRC.
    always_comb
    begin
        crc_next = crc_reg;
        if (adv && cur_covered)
        begin
            crc_next = crc_byte((step_reg == STEP_SYNC0) ? CRC_INIT : crc_reg,
                                cur_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            step_reg      <= STEP_SYNC0;
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            step_reg      <= step_next;
            crc_reg       <= crc_next;
            if (adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head_cmd;
        end
        if (adv)
        begin
            out_byte_reg <= cur_byte;
            out_end_reg  <= cur_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_end  = out_end_reg;

endmodule

// ===== rtl/crc32_message_framer_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// crc32_message_framer_top
// Frames payload bytes as A5 FF, length, type, payload and a CRC-32 trailer.
// ============================================================================
//  Channel   Direction  Handshake            Contents
//  s_*       in         s_tvalid / s_tready  payload bytes, start flag in tuser
//  m_*       out        m_tvalid / m_tready  frame bytes, tlast on last CRC byte
//
// Each output transfer carries one frame byte; a payload byte in mid-message
// yields one byte, a message start adds the six header bytes, a last byte the four CRC bytes.
// Input is taken one item per cycle until the four-entry command queue fills.
// The first frame byte passes through the queue entry, the command register and
// the output register before it is presented on m_tvalid.
// Reset clears the message tracking, the queue and the CRC; no clearing pass.
// Either side may stall; the queue and the output register keep data intact.
// ============================================================================
module crc32_message_framer_top #(
    parameter int MAX_PAYLOAD = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // payload_byte[7:0], message_type[23:8],
                                  // payload_length[32:24], zero pad [39:33]
    input  logic        s_tuser,  // starts_message[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // frame_byte[7:0]
    output logic        m_tlast   // frame_end
);
    import cmf_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic queue_full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    // Front part: accept and classify.
    cmf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .payload_byte   (s_tdata[7:0]),
        .starts_message (s_tuser),
        .message_type   (s_tdata[23:8]),
        .payload_length (s_tdata[32:24]),
        .push           (push),
        .push_cmd       (push_cmd),
        .queue_full     (queue_full)
    );

    // Command queue.
    cmf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .full       (queue_full)
    );

    // Back part: byte sequencing and CRC.
    cmf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .frame_byte (m_tdata),
        .frame_end  (m_tlast)
    );

endmodule

// ===== test/crc32_message_framer_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// crc32_message_framer_top_tb
// Self-checking bench for the CRC-32 message framer.
// A directed table covers stray bytes, empty and one-byte messages, length
// saturation and restarts. Random messages follow under several idle and
// stall patterns, with one long output hold-off. A local framer model
// predicts every frame byte, and each output transfer is checked against it.
// ============================================================================
module crc32_message_framer_top_tb;

    import cmf_pkg::*;

    localparam int PAYLOAD_CAP  = 256;
    localparam int ITEM_TARGET  = 460;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_LIMIT = 10;

    // One expected frame byte.
    typedef struct packed {
        logic [7:0] octet;
        logic       last;
    } frame_beat_t;

    // One row of the directed table. A want field of -1 means the row is
    // checked only through the framer model.
    typedef struct {
        logic [7:0]  pbyte;
        logic        start;
        logic [15:0] mtype;
        logic [8:0]  plen;
        int          want_beats;
        int          want_lenw;
    } stim_row_t;

    localparam int NUM_ROWS = 22;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // payload_byte[7:0], message_type[23:8],
                                 // payload_length[32:24], zero pad [39:33]
    logic        s_tuser  = 1'b0; // starts_message[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // frame_byte[7:0]
    logic        m_tlast;         // frame_end

    // Framer model state.
    logic [31:0] crc_acc;
    logic [8:0]  bytes_remaining;
    logic        msg_open;
    logic [15:0] last_length_word;
    frame_beat_t frame_bytes_due[$];

    // Traffic shaping.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit hold_request    = 1'b0;
    bit hold_done       = 1'b0;
    int hold_left       = 0;

    // Bookkeeping.
    int mismatches    = 0;
    int items_sent    = 0;
    int frames_closed = 0;
    int bytes_checked = 0;
    int stray_items   = 0;
    int restarts      = 0;
    int cycle_count   = 0;
    frame_beat_t beat_seen;

    stim_row_t dir_rows [NUM_ROWS];

    crc32_message_framer_top #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reflected CRC-32, one data bit at a time.
    function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] d);
        logic fb;
        for (int k = 0; k < 8; k++)
        begin
            fb = c[0] ^ d[k];
            c  = c >> 1;
            if (fb)
                c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    function automatic void note_mismatch(input string what, input int want, input int got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    // A frame byte covered by the CRC.
    function automatic void push_covered(input logic [7:0] b);
        frame_bytes_due.push_back('{octet: b, last: 1'b0});
        crc_acc = crc32_next(crc_acc, b);
    endfunction

    // The four CRC bytes, low byte first, then the frame closes.
    function automatic void push_trailer();
        for (int k = 0; k < 4; k++)
            frame_bytes_due.push_back('{octet: crc_acc[8*k +: 8], last: (k == 3)});
        crc_acc         = CRC_INIT;
        bytes_remaining = '0;
        msg_open        = 1'b0;
        frames_closed++;
    endfunction

    // Works out the frame bytes that one accepted item releases.
    function automatic int predict_item(input logic [7:0] pbyte, input logic start,
                                        input logic [15:0] mtype, input logic [8:0] plen);
        logic [8:0]  cap;
        logic [15:0] lenw;
        int          before_size;
        before_size = frame_bytes_due.size();
        if (start)
        begin
            if (msg_open)
                restarts++;
            cap  = (plen > PAYLOAD_CAP) ? 9'(PAYLOAD_CAP) : plen;
            lenw = {7'd0, cap} + 16'd2;
            if (lenw < MIN_LENGTH_FIELD)
                lenw = MIN_LENGTH_FIELD;
            last_length_word = lenw;
            crc_acc = CRC_INIT;
            push_covered(SYNC_FIRST);
            push_covered(SYNC_SECOND);
            push_covered(lenw[7:0]);
            push_covered(lenw[15:8]);
            push_covered(mtype[7:0]);
            push_covered(mtype[15:8]);
            bytes_remaining = cap;
            msg_open        = (cap != 0);
            if (cap == 0)
            begin
                push_trailer();
                return frame_bytes_due.size() - before_size;
            end
        end
        else if (!msg_open)
        begin
            stray_items++;
            return 0;
        end
        push_covered(pbyte);
        bytes_remaining = bytes_remaining - 9'd1;
        if (bytes_remaining == 0)
            push_trailer();
        return frame_bytes_due.size() - before_size;
    endfunction

    // Offers one item, waits for its transfer and records what it releases.
    task automatic send_item(input logic [7:0] pbyte, input logic start,
                             input logic [15:0] mtype, input logic [8:0] plen,
                             output int produced);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, plen, mtype, pbyte};
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        produced = predict_item(pbyte, start, mtype, plen);
        items_sent++;
    endtask

    // A start item and its payload, sometimes cut short so that the next
    // start abandons it.
    task automatic send_random_message(input int len_req);
        int body;
        int n;
        send_item(8'($urandom_range(255)), 1'b1, 16'($urandom_range(65535)),
                  9'(len_req), n);
        body = (len_req > PAYLOAD_CAP) ? PAYLOAD_CAP - 1 : ((len_req > 0) ? len_req - 1 : 0);
        if (body > 0 && $urandom_range(99) < 8)
            body = $urandom_range(body - 1, 0);
        for (int i = 0; i < body; i++)
            send_item(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)),
                      9'($urandom_range(511)), n);
    endtask

    // Mostly short messages, with a few longer ones.
    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        else if (r < 70)
            return $urandom_range(6, 1);
        else if (r < 92)
            return $urandom_range(30, 7);
        return $urandom_range(80, 31);
    endfunction

    // Receiver: random stalls, plus one long hold-off when asked for.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_done)
        begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Output check against the oldest expected frame byte.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                note_mismatch("frame byte with nothing expected", -1, m_tdata);
            end
            else
            begin
                beat_seen = frame_bytes_due.pop_front();
                if (beat_seen.octet !== m_tdata)
                    note_mismatch("frame_byte", beat_seen.octet, m_tdata);
                if (beat_seen.last !== m_tlast)
                    note_mismatch("frame_end", beat_seen.last, m_tlast);
                bytes_checked++;
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int n;
        int stray_count;

        crc_acc          = CRC_INIT;
        bytes_remaining  = '0;
        msg_open         = 1'b0;
        last_length_word = '0;

        //            byte   start type      len     beats  length word
        dir_rows = '{
            '{8'h3C, 1'b0, 16'hFFFF, 9'h1FF,  0, -1},  // stray byte after reset
            '{8'hFF, 1'b1, 16'h0000, 9'd0,   10,  4},  // empty message
            '{8'h00, 1'b1, 16'hFFFF, 9'd1,   11,  4},  // one-byte message
            '{8'h80, 1'b1, 16'h1234, 9'd2,    7,  4},
            '{8'h7F, 1'b0, 16'hFFFF, 9'h1FF,  5, -1},  // last byte, fields ignored
            '{8'h55, 1'b0, 16'h0000, 9'd0,    0, -1},  // stray byte after a frame
            '{8'h01, 1'b1, 16'hA55A, 9'd3,    7,  5},
            '{8'h02, 1'b0, 16'h0F0F, 9'd7,    1, -1},
            '{8'h03, 1'b0, 16'hF0F0, 9'd0,    5, -1},
            '{8'hAA, 1'b1, 16'hABCD, 9'd9,    7, 11},
            '{8'hBB, 1'b0, 16'h0000, 9'd0,    1, -1},
            '{8'hCC, 1'b1, 16'h00FF, 9'd0,   10,  4},  // restart into an empty one
            '{8'h10, 1'b1, 16'hFF00, 9'h1FF,  7, 258}, // saturated length
            '{8'h11, 1'b0, 16'h5555, 9'd1,    1, -1},
            '{8'h12, 1'b1, 16'h8001, 9'd257,  7, 258}, // restart, just over the cap
            '{8'h13, 1'b0, 16'hAAAA, 9'd2,    1, -1},
            '{8'h14, 1'b1, 16'h0001, 9'd256,  7, 258}, // restart, at the cap
            '{8'hE0, 1'b1, 16'h7FFE, 9'd4,    7,  6},  // restart again
            '{8'hE1, 1'b0, 16'h0000, 9'd0,    1, -1},
            '{8'hE2, 1'b0, 16'h0000, 9'd0,    1, -1},
            '{8'hE3, 1'b0, 16'h0000, 9'd0,    5, -1},
            '{8'h99, 1'b0, 16'h1234, 9'd5,    0, -1}   // stray byte
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling.
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            send_item(dir_rows[r].pbyte, dir_rows[r].start, dir_rows[r].mtype,
                      dir_rows[r].plen, n);
            if (dir_rows[r].want_beats >= 0 && n != dir_rows[r].want_beats)
                note_mismatch($sformatf("frame bytes for table row %0d", r),
                              dir_rows[r].want_beats, n);
            if (dir_rows[r].want_lenw >= 0 && last_length_word != dir_rows[r].want_lenw)
                note_mismatch($sformatf("length word for table row %0d", r),
                              dir_rows[r].want_lenw, last_length_word);
        end

        // One full-size message while the receiver holds off, so the
        // command queue fills and the input stalls.
        hold_request = 1'b1;
        send_random_message($urandom_range(511, PAYLOAD_CAP));

        // Random messages under the idle and stall patterns.
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent < 310)
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 0;
            end
            else if (items_sent < 360)
            begin
                sender_idle_pct = 83;
                recv_stall_pct  = 0;
            end
            else if (items_sent < 410)
            begin
                sender_idle_pct = 0;
                recv_stall_pct  = 83;
            end
            else
            begin
                sender_idle_pct = 9;
                recv_stall_pct  = 9;
            end
            if ($urandom_range(99) < 10)
            begin
                stray_count = $urandom_range(3, 1);
                for (int i = 0; i < stray_count; i++)
                    send_item(8'($urandom_range(255)), 1'b0, 16'($urandom_range(65535)),
                              9'($urandom_range(511)), n);
            end
            send_random_message(pick_length());
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        // Drain and let any late output show up.
        while (frame_bytes_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d items; %0d frames closed, %0d frame bytes checked.",
                 items_sent, frames_closed, bytes_checked);
        $display("%0d stray items ignored, %0d open messages abandoned by a restart.",
                 stray_items, restarts);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
